// File: sv/ecc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_pkg
// Types, codes and reset constants shared by the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic [5:0]  TOP_FLOOR_RST = 6'd20;
  localparam logic [3:0]  DWELL_RST     = 4'd3;
  localparam logic [5:0]  FLOOR_MIN     = 6'd1;
  localparam logic [5:0]  TOP_FLOOR_MIN = 6'd2;
  localparam logic [11:0] WEIGHT_MAX    = 12'd4095;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_t;

  typedef enum logic {
    REG_TOP_FLOOR   = 1'b0,
    REG_DWELL_TICKS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_UP         = 3'd1,
    MODE_DOWN       = 3'd2,
    MODE_DWELL_UP   = 3'd3,
    MODE_DWELL_DOWN = 3'd4
  } motion_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STOP_RD,
    S_STOP_CHK,
    S_WALK,
    S_PACK,
    S_FIN,
    S_OUT
  } seq_state_t;

  typedef struct packed {
    logic       opcode;
    logic [5:0] pickup_floor;
    logic [5:0] dest_floor;
    logic       wants_up;
    logic [7:0] rider_weight;
  } ecc_in_t;

  typedef struct packed {
    logic [2:0]  motion_state;
    logic [5:0]  floor;
    logic [11:0] load_weight;
    logic        add_rejected;
  } ecc_out_t;

  // One stored passenger request.
  typedef struct packed {
    logic [5:0] depart;
    logic [5:0] dest;
    logic       up;
    logic [7:0] weight;
    logic       boarded;
    logic       gone;
  } ecc_entry_t;

  typedef struct packed {
    logic [5:0] top_floor;
    logic [3:0] dwell_ticks;
  } ecc_cfg_t;

endpackage
`default_nettype wire

// File: sv/ecc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ecc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/ecc_alu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_alu
// Shared entry unit: floor match for drop and boarding, and the saturating
// add or subtract of the rider weight into the carried load.
// ----------------------------------------------------------------------------
module ecc_alu (
  input  wire ecc_pkg::ecc_entry_t entry,
  input  wire logic [5:0]          car_floor,
  input  wire logic [11:0]         load,
  output ecc_pkg::ecc_entry_t      entry_new,
  output logic [11:0]              load_new,
  output logic                     hit
);
  import ecc_pkg::*;

  logic        drop;
  logic        board;
  logic [12:0] sum;

  assign drop  = entry.boarded && (entry.dest == car_floor);
  assign board = !entry.boarded && (entry.depart == car_floor);
  assign hit   = drop || board;

  // One adder serves both directions; bit 12 is carry on add, borrow on subtract.
  assign sum = board ? ({1'b0, load} + {5'd0, entry.weight})
                     : ({1'b0, load} - {5'd0, entry.weight});

  always_comb begin
    entry_new = entry;
    load_new  = load;
    if (drop) begin
      entry_new.gone = 1'b1;
      load_new       = sum[12] ? 12'd0 : sum[11:0];
    end else if (board) begin
      entry_new.boarded = 1'b1;
      load_new          = sum[12] ? WEIGHT_MAX : sum[11:0];
    end
  end

endmodule
`default_nettype wire

// File: sv/ecc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ecc_ctrl
// Sequencer for the car: handles add and tick items, walks the request
// table newest first through the shared entry unit, then compacts it.
// ----------------------------------------------------------------------------
module ecc_ctrl #(
  parameter int TABLE_DEPTH = ecc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire ecc_pkg::ecc_cfg_t cfg,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire ecc_pkg::ecc_in_t req_data,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output ecc_pkg::ecc_out_t     res_data
);
  import ecc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = $bits(ecc_entry_t);
  localparam logic [CW-1:0] COUNT_FULL = CW'(TABLE_DEPTH);

  seq_state_t state, state_next;
  motion_t    mode, mode_next;
  logic [5:0]  car_floor, car_floor_next;
  logic [11:0] load, load_next;
  logic [3:0]  dwell_left, dwell_left_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] issue_left, issue_left_next;
  logic [CW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_addr, rd_addr_next;
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic          rd_pend, rd_pend_next;
  logic          rejected, rejected_next;
  logic          hit, hit_next;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  ecc_entry_t    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;
  ecc_entry_t    rd_entry;

  ecc_entry_t    alu_entry;
  logic [11:0]   alu_load;
  logic          alu_hit;

  logic [CW-1:0] cnt_m1;
  logic          accept;
  logic          moving_up;
  logic [6:0]    step_floor;
  logic [5:0]    moved_floor;
  logic          pass_done;
  motion_t       fin_mode;

  assign accept   = req_valid && req_ready;
  assign cnt_m1   = count - CW'(1);
  assign rd_entry = ecc_entry_t'(ram_rdata);
  assign moving_up = (mode == MODE_UP);
  assign pass_done = (issue_left == '0) && !rd_pend;

  // Next floor for a moving tick, held between floor one and the top floor.
  always_comb begin
    if (moving_up) begin
      step_floor = {1'b0, car_floor} + 7'd1;
    end else if (car_floor > FLOOR_MIN) begin
      step_floor = {1'b0, car_floor} - 7'd1;
    end else begin
      step_floor = {1'b0, FLOOR_MIN};
    end
    if (step_floor > {1'b0, cfg.top_floor}) begin
      moved_floor = cfg.top_floor;
    end else begin
      moved_floor = step_floor[5:0];
    end
  end

  // Mode after a walk: a hit or an end floor turns the move into a dwell.
  always_comb begin
    if (hit) begin
      fin_mode = moving_up ? MODE_DWELL_UP : MODE_DWELL_DOWN;
    end else begin
      fin_mode = moving_up ? MODE_UP : MODE_DOWN;
    end
    if (moving_up && car_floor == cfg.top_floor) begin
      fin_mode = MODE_DWELL_DOWN;
    end
    if (!moving_up && car_floor == FLOOR_MIN) begin
      fin_mode = MODE_DWELL_UP;
    end
  end

  ecc_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ecc_alu u_alu (
    .entry    (rd_entry),
    .car_floor(car_floor),
    .load     (load),
    .entry_new(alu_entry),
    .load_new (alu_load),
    .hit      (alu_hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (req_data.opcode == OP_ADD) begin
            state_next = S_OUT;
          end else if (mode == MODE_STOP) begin
            state_next = (count != '0) ? S_STOP_RD : S_OUT;
          end else if (mode == MODE_UP || mode == MODE_DOWN) begin
            state_next = S_WALK;
          end else begin
            state_next = S_OUT;
          end
        end
      end
      S_STOP_RD:  state_next = S_STOP_CHK;
      S_STOP_CHK: state_next = S_OUT;
      S_WALK:     if (pass_done) state_next = S_PACK;
      S_PACK:     if (pass_done) state_next = S_FIN;
      S_FIN:      state_next = S_OUT;
      S_OUT:      if (res_ready) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mode_next       = mode;
    car_floor_next  = car_floor;
    load_next       = load;
    dwell_left_next = dwell_left;
    count_next      = count;
    issue_left_next = issue_left;
    wr_ptr_next     = wr_ptr;
    rd_addr_next    = rd_addr;
    pend_addr_next  = pend_addr;
    rd_pend_next    = rd_pend;
    rejected_next   = rejected;
    hit_next        = hit;
    ram_we          = 1'b0;
    ram_waddr       = count[AW-1:0];
    ram_wdata       = alu_entry;
    ram_raddr       = rd_addr;
    req_ready       = (state == S_IDLE);
    res_valid       = (state == S_OUT);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rejected_next = 1'b0;
          if (req_data.opcode == OP_ADD) begin
            if (count == COUNT_FULL) begin
              rejected_next = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = count[AW-1:0];
              ram_wdata = '{depart:  req_data.pickup_floor,
                            dest:    req_data.dest_floor,
                            up:      req_data.wants_up,
                            weight:  req_data.rider_weight,
                            boarded: 1'b0,
                            gone:    1'b0};
              count_next = count + CW'(1);
            end
          end else begin
            unique case (mode)
              MODE_STOP: ;
              MODE_UP, MODE_DOWN: begin
                car_floor_next  = moved_floor;
                hit_next        = 1'b0;
                issue_left_next = count;
                rd_addr_next    = cnt_m1[AW-1:0];
                rd_pend_next    = 1'b0;
              end
              MODE_DWELL_UP, MODE_DWELL_DOWN: begin
                if (dwell_left != 4'd0) begin
                  dwell_left_next = dwell_left - 4'd1;
                end else if (count == '0) begin
                  mode_next = MODE_STOP;
                end else begin
                  mode_next = (mode == MODE_DWELL_UP) ? MODE_UP : MODE_DOWN;
                end
              end
              default: mode_next = MODE_STOP;
            endcase
          end
        end
      end

      S_STOP_RD: begin
        // The newest request sits at the highest occupied address.
        ram_raddr = cnt_m1[AW-1:0];
      end

      S_STOP_CHK: begin
        if (rd_entry.depart < car_floor) begin
          mode_next = MODE_DOWN;
        end else if (rd_entry.depart > car_floor) begin
          mode_next = MODE_UP;
        end else begin
          mode_next       = rd_entry.up ? MODE_DWELL_UP : MODE_DWELL_DOWN;
          dwell_left_next = cfg.dwell_ticks;
        end
      end

      S_WALK: begin
        // Reads run newest to oldest; each entry is written back in place
        // in the cycle after its read.
        if (issue_left != '0) begin
          rd_addr_next    = rd_addr - AW'(1);
          issue_left_next = issue_left - CW'(1);
          rd_pend_next    = 1'b1;
          pend_addr_next  = rd_addr;
        end else begin
          rd_pend_next = 1'b0;
        end
        if (rd_pend) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr;
          ram_wdata = alu_entry;
          load_next = alu_load;
          if (alu_hit) begin
            hit_next = 1'b1;
          end
        end
        if (pass_done) begin
          issue_left_next = count;
          rd_addr_next    = '0;
          wr_ptr_next     = '0;
        end
      end

      S_PACK: begin
        // Oldest to newest: surviving entries slide down over dropped ones.
        if (issue_left != '0) begin
          rd_addr_next    = rd_addr + AW'(1);
          issue_left_next = issue_left - CW'(1);
          rd_pend_next    = 1'b1;
        end else begin
          rd_pend_next = 1'b0;
        end
        if (rd_pend && !rd_entry.gone) begin
          ram_we      = 1'b1;
          ram_waddr   = wr_ptr[AW-1:0];
          ram_wdata   = rd_entry;
          wr_ptr_next = wr_ptr + CW'(1);
        end
        if (pass_done) begin
          count_next = wr_ptr;
        end
      end

      S_FIN: begin
        mode_next = fin_mode;
        if (fin_mode != mode) begin
          dwell_left_next = cfg.dwell_ticks;
        end
      end

      S_OUT: ;

      default: ;
    endcase
  end

  assign res_data = '{motion_state: mode,
                      floor:        car_floor,
                      load_weight:  load,
                      add_rejected: rejected};

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      mode       <= MODE_STOP;
      car_floor  <= FLOOR_MIN;
      load       <= '0;
      dwell_left <= '0;
      count      <= '0;
      issue_left <= '0;
      wr_ptr     <= '0;
      rd_pend    <= 1'b0;
      rejected   <= 1'b0;
      hit        <= 1'b0;
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      car_floor  <= car_floor_next;
      load       <= load_next;
      dwell_left <= dwell_left_next;
      count      <= count_next;
      issue_left <= issue_left_next;
      wr_ptr     <= wr_ptr_next;
      rd_pend    <= rd_pend_next;
      rejected   <= rejected_next;
      hit        <= hit_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr   <= rd_addr_next;
    pend_addr <= pend_addr_next;
  end

endmodule
`default_nettype wire

// File: sv/elevator_car_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// elevator_car_controller
// Controller for one elevator car with a table of passenger requests.
// ----------------------------------------------------------------------------
//   req channel (valid/ready) carries one item, an add of a passenger request
//   or a time tick; each accepted item gives exactly one transfer on rsp with
//   the motion state, floor, carried load and the table-full flag of an add.
//   cfg channel (always ready) writes top_floor (index 0) and dwell_ticks
//   (index 1); write it only while the block is idle.
//   An add, a dwell tick or a stopped tick with no requests goes straight
//   to the result; a stopped car starting on a request first reads its
//   newest request to choose its next mode; a moving tick walks the table
//   RAM once to drop and board riders and once more to compact it.
//   req_ready is low from the accept until the result is loaded, so the
//   block takes no new item before it is through with the last one.
//   A result waits in the output register while rsp_ready is low; the next
//   item may be accepted meanwhile, but its result holds until that register
//   is free. Reset empties the table at once (fill count), stops the car at
//   floor 1 with no load, and restores the register defaults.
// ----------------------------------------------------------------------------
module elevator_car_controller #(
  parameter int TABLE_DEPTH = ecc_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire ecc_pkg::ecc_in_t req_data,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output ecc_pkg::ecc_out_t     rsp_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic             cfg_index,
  input  wire logic [5:0]       cfg_data
);
  import ecc_pkg::*;

  logic [5:0] top_floor;
  logic [3:0] dwell_ticks;
  ecc_cfg_t   cfg;
  logic       res_valid;
  logic       res_ready;
  ecc_out_t   res_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_floor   <= TOP_FLOOR_RST;
      dwell_ticks <= DWELL_RST;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TOP_FLOOR:   top_floor   <= cfg_data;
        REG_DWELL_TICKS: dwell_ticks <= cfg_data[3:0];
      endcase
    end
  end

  // A top floor below two behaves as two.
  assign cfg.top_floor   = (top_floor < TOP_FLOOR_MIN) ? TOP_FLOOR_MIN : top_floor;
  assign cfg.dwell_ticks = dwell_ticks;

  ecc_ctrl #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req_data (req_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data (res_data)
  );

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp_data <= res_data;
    end
  end

endmodule
`default_nettype wire
